FILE: hw/rtl/dsfw_pkg.sv
`timescale 1ns / 1ps

package dsfw_pkg;

	localparam int unsigned TimeW = 64;
	localparam int unsigned CfgIdxW = 3;

	// watchdog mode
	typedef enum logic [2:0] {
		ST_STARTUP  = 3'd0,
		ST_HEALTHY  = 3'd1,
		ST_STRICT   = 3'd2,
		ST_FALLBACK = 3'd3,
		ST_RECOVER  = 3'd4
	} dsfw_state_t;

	// input beat source (tuser)
	typedef enum logic [1:0] {
		SRC_EVAL   = 2'd0,
		SRC_A      = 2'd1,
		SRC_B      = 2'd2,
		SRC_UNUSED = 2'd3
	} dsfw_src_t;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_FALLBACK_POLICY = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STALE_TIMEOUT   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STARTUP_GRACE   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_START_TIME      = 3'd3;

	typedef struct packed {
		logic             fallback_policy;
		logic [TimeW-1:0] stale_timeout;
		logic [TimeW-1:0] startup_grace;
		logic [TimeW-1:0] start_time;
	} dsfw_cfg_t;

	typedef struct packed {
		dsfw_state_t      mode_state;
		logic             seen_a;
		logic             seen_b;
		logic [TimeW-1:0] last_time_a;
		logic [TimeW-1:0] last_time_b;
		logic             recover_seen_a;
		logic             recover_seen_b;
	} dsfw_ctx_t;

endpackage

FILE: hw/rtl/dsfw_step.sv
`timescale 1ns / 1ps

module dsfw_step import dsfw_pkg::*; (
	input  dsfw_cfg_t        cfg,
	input  dsfw_ctx_t        ctx,
	input  dsfw_src_t        src,
	input  logic [TimeW-1:0] now_time,
	output dsfw_ctx_t        ctx_next,
	output logic             flush
);

	dsfw_ctx_t   rec;
	logic        fresh_a;
	logic        fresh_b;
	logic        both;
	logic        grace_over;
	dsfw_state_t target;

	// record the arrival first; freshness is judged on the updated times
	always_comb begin
		rec = ctx;
		if (src == SRC_A) begin
			rec.seen_a      = 1'b1;
			rec.last_time_a = now_time;
		end else if (src == SRC_B) begin
			rec.seen_b      = 1'b1;
			rec.last_time_b = now_time;
		end
		if (ctx.mode_state == ST_RECOVER) begin
			if (src == SRC_A) begin
				rec.recover_seen_a = 1'b1;
			end else if (src == SRC_B) begin
				rec.recover_seen_b = 1'b1;
			end
		end
	end

	assign fresh_a = rec.seen_a && (now_time >= rec.last_time_a)
		&& ((now_time - rec.last_time_a) <= cfg.stale_timeout);
	assign fresh_b = rec.seen_b && (now_time >= rec.last_time_b)
		&& ((now_time - rec.last_time_b) <= cfg.stale_timeout);
	assign both = fresh_a && fresh_b;
	assign grace_over = (now_time >= cfg.start_time)
		&& ((now_time - cfg.start_time) >= cfg.startup_grace);
	assign target = (cfg.fallback_policy && fresh_a && !fresh_b) ? ST_FALLBACK : ST_STRICT;

	always_comb begin
		ctx_next = rec;
		flush    = 1'b0;
		unique case (ctx.mode_state)
			ST_STARTUP: begin
				if (both) begin
					ctx_next.mode_state = ST_HEALTHY;
				end else if (grace_over) begin
					ctx_next.mode_state = target;
					flush               = 1'b1;
				end
			end
			ST_HEALTHY: begin
				if (!both) begin
					ctx_next.mode_state = target;
					flush               = 1'b1;
				end
			end
			ST_STRICT, ST_FALLBACK: begin
				if (both) begin
					ctx_next.mode_state     = ST_RECOVER;
					ctx_next.recover_seen_a = 1'b0;
					ctx_next.recover_seen_b = 1'b0;
					flush                   = 1'b1;
				end else if (target != ctx.mode_state) begin
					ctx_next.mode_state = target;
					flush               = 1'b1;
				end
			end
			default: begin
				if (!both) begin
					ctx_next.mode_state     = target;
					ctx_next.recover_seen_a = 1'b0;
					ctx_next.recover_seen_b = 1'b0;
					flush                   = 1'b1;
				end else if (rec.recover_seen_a && rec.recover_seen_b) begin
					ctx_next.mode_state = ST_HEALTHY;
				end
			end
		endcase
	end

endmodule

FILE: hw/rtl/dual_sensor_freshness_watchdog_core.sv
`timescale 1ns / 1ps
// Channel  | Dir | Beat fields
// s_axis   | in  | tuser: mode[1:0]; tdata: now_time[63:0]
// m_axis   | out | tdata: previous_state[2:0], current_state[5:3],
//          |     |        state_changed[6], buf_flush[7]
// cfg      | in  | cfg_index[2:0], cfg_data[63:0]; always ready
//
// One beat per cycle sustained while the output is not stalled. An accepted beat
// sits in the input register, is evaluated against the watchdog state by a
// combinational step and lands in the output register once the output can take it.
// The combinational path is three parallel 64-bit subtract-and-compare pairs. Reset clears the
// mode to startup and all seen and recovery flags. A stalled output holds its
// beat; the input register still takes one more beat behind it.

module dual_sensor_freshness_watchdog_core import dsfw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TimeW-1:0]   s_tdata,   // now_time[63:0]
	input  logic [1:0]         s_tuser,   // mode[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // previous_state, current_state, state_changed,
	                                      // buf_flush
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimeW-1:0]   cfg_data
);

	dsfw_cfg_t        cfg_q;
	dsfw_ctx_t        ctx_q;
	dsfw_ctx_t        ctx_next;
	logic             flush;

	logic             valid_s1;
	dsfw_src_t        src_s1;
	logic [TimeW-1:0] now_s1;

	logic             valid_s2;
	logic [7:0]       data_s2;

	logic             advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fallback_policy <= 1'b0;
			cfg_q.stale_timeout   <= TimeW'(1);
			cfg_q.startup_grace   <= '0;
			cfg_q.start_time      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FALLBACK_POLICY: cfg_q.fallback_policy <= cfg_data[0];
				REG_STALE_TIMEOUT:   cfg_q.stale_timeout   <= cfg_data;
				REG_STARTUP_GRACE:   cfg_q.startup_grace   <= cfg_data;
				REG_START_TIME:      cfg_q.start_time      <= cfg_data;
				default: ;
			endcase
		end
	end

	dsfw_step u_step (
		.cfg      (cfg_q),
		.ctx      (ctx_q),
		.src      (src_s1),
		.now_time (now_s1),
		.ctx_next (ctx_next),
		.flush    (flush)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.mode_state     <= ST_STARTUP;
			ctx_q.seen_a         <= 1'b0;
			ctx_q.seen_b         <= 1'b0;
			ctx_q.last_time_a    <= '0;
			ctx_q.last_time_b    <= '0;
			ctx_q.recover_seen_a <= 1'b0;
			ctx_q.recover_seen_b <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			src_s1 <= dsfw_src_t'(s_tuser);
			now_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {flush, ctx_next.mode_state != ctx_q.mode_state,
				ctx_next.mode_state, ctx_q.mode_state};
		end
	end

endmodule

FILE: hw/rtl/dsfw_checker.sv
`timescale 1ns / 1ps

module dsfw_checker import dsfw_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// input side only backs up when the output is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input not ready without output stall");

	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6] == (m_tdata[2:0] != m_tdata[5:3]))
		else $error("changed flag disagrees with states");

	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> m_tdata[5:3] == ST_STRICT
			|| m_tdata[5:3] == ST_FALLBACK || m_tdata[5:3] == ST_RECOVER)
		else $error("flush into startup or healthy");

	a_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] && m_tdata[5:3] == ST_HEALTHY
			|-> m_tdata[2:0] == ST_STARTUP || m_tdata[2:0] == ST_RECOVER)
		else $error("healthy entered from a stop state");

endmodule

bind dual_sensor_freshness_watchdog_core dsfw_checker u_dsfw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_dual_sensor_freshness_watchdog_core.sv
`timescale 1ns / 1ps

module tb_dual_sensor_freshness_watchdog_core;
	import dsfw_pkg::*;

	class watchdog_scoreboard;
		bit          policy;
		bit [63:0]   tmo;
		bit [63:0]   grace;
		bit [63:0]   t_start;
		dsfw_state_t st;
		bit          seen_a;
		bit          seen_b;
		bit [63:0]   last_a;
		bit [63:0]   last_b;
		bit          rec_a;
		bit          rec_b;
		bit [7:0]    expected_verdicts[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned flushes;
		bit [4:0]    visited;

		function new();
			policy = 1'b0;
			tmo = 64'd1;
			grace = '0;
			t_start = '0;
			st = ST_STARTUP;
			seen_a = 1'b0;
			seen_b = 1'b0;
			last_a = '0;
			last_b = '0;
			rec_a = 1'b0;
			rec_b = 1'b0;
			visited = 5'b00001;
		endfunction

		function bit fresh(bit seen, bit [63:0] last, bit [63:0] now);
			return seen && now >= last && (now - last) <= tmo;
		endfunction

		function dsfw_state_t missing_target(bit [63:0] now);
			if (policy && fresh(seen_a, last_a, now) && !fresh(seen_b, last_b, now))
				return ST_FALLBACK;
			return ST_STRICT;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
			case (idx)
				REG_FALLBACK_POLICY: policy = val[0];
				REG_STALE_TIMEOUT:   tmo = val;
				REG_STARTUP_GRACE:   grace = val;
				REG_START_TIME:      t_start = val;
				default: ;
			endcase
		endfunction

		function void note_sample(dsfw_src_t src, bit [63:0] now);
			dsfw_state_t was;
			dsfw_state_t target;
			bit          flush;
			bit          both;
			was = st;
			flush = 1'b0;
			if (src == SRC_A) begin
				seen_a = 1'b1;
				last_a = now;
			end else if (src == SRC_B) begin
				seen_b = 1'b1;
				last_b = now;
			end
			if (st == ST_RECOVER) begin
				if (src == SRC_A)
					rec_a = 1'b1;
				else if (src == SRC_B)
					rec_b = 1'b1;
			end
			both = fresh(seen_a, last_a, now) && fresh(seen_b, last_b, now);
			case (st)
				ST_STARTUP: begin
					if (both) begin
						st = ST_HEALTHY;
					end else if (now >= t_start && (now - t_start) >= grace) begin
						st = missing_target(now);
						flush = 1'b1;
					end
				end
				ST_HEALTHY: begin
					if (!both) begin
						st = missing_target(now);
						flush = 1'b1;
					end
				end
				ST_STRICT, ST_FALLBACK: begin
					if (both) begin
						st = ST_RECOVER;
						rec_a = 1'b0;
						rec_b = 1'b0;
						flush = 1'b1;
					end else begin
						target = missing_target(now);
						if (target != st) begin
							st = target;
							flush = 1'b1;
						end
					end
				end
				default: begin
					if (!both) begin
						st = missing_target(now);
						rec_a = 1'b0;
						rec_b = 1'b0;
						flush = 1'b1;
					end else if (rec_a && rec_b) begin
						st = ST_HEALTHY;
					end
				end
			endcase
			visited[st] = 1'b1;
			if (flush)
				flushes++;
			// buf_flush, state_changed, current_state, previous_state
			expected_verdicts.push_back({flush, st != was, 3'(st), 3'(was)});
		endfunction

		function void compare_field(string name, bit [2:0] exp, logic [2:0] act);
			if (act !== exp) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on %s at %0t: expected %0d, got %0d",
						name, $time, exp, act);
			end
		endfunction

		function void check_verdict(logic [7:0] got);
			bit [7:0] exp;
			if (expected_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat at %0t: %h", $time, got);
				return;
			end
			exp = expected_verdicts.pop_front();
			checked++;
			compare_field("previous_state", exp[2:0], got[2:0]);
			compare_field("current_state", exp[5:3], got[5:3]);
			compare_field("state_changed", {2'b0, exp[6]}, {2'b0, got[6]});
			compare_field("buf_flush", {2'b0, exp[7]}, {2'b0, got[7]});
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	localparam int STUCK_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TimeW-1:0]   s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [TimeW-1:0]   cfg_data;

	watchdog_scoreboard board;
	bit                 calm;
	int                 stuck_cycles = 0;
	int                 samples;
	int                 settings;

	dual_sensor_freshness_watchdog_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: stall in bursts until the final phase
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 17);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_verdict(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(bit pol, logic [TimeW-1:0] tmo, logic [TimeW-1:0] grace,
			logic [TimeW-1:0] t_start);
		write_reg(REG_FALLBACK_POLICY, {63'd0, pol});
		write_reg(REG_STALE_TIMEOUT, tmo);
		write_reg(REG_STARTUP_GRACE, grace);
		write_reg(REG_START_TIME, t_start);
		settings++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(dsfw_src_t src, logic [TimeW-1:0] now);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = src;
		s_tdata = now;
		do @(posedge clk); while (!s_tready);
		board.note_sample(src, now);
		samples++;
		@(negedge clk);
	endtask

	// hold the input until every outstanding verdict has come back
	task automatic drain();
		s_tvalid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [TimeW-1:0] cur;
		logic [TimeW-1:0] tmo;
		logic [TimeW-1:0] grace;
		logic [TimeW-1:0] t_start;
		dsfw_src_t        src;
		int               span;
		int               drop;
		int               r;
		board = new();
		calm = 1'b0;
		samples = 0;
		settings = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = SRC_EVAL;
		cfg_valid = 1'b0;
		cfg_index = REG_FALLBACK_POLICY;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// startup grace, fallback, strict stop, recovery, stale and backward time
		write_all(1'b1, 64'd100, 64'd1000, 64'd5000);
		send_sample(SRC_EVAL, 64'd0);
		send_sample(SRC_A, 64'd10);
		send_sample(SRC_EVAL, 64'd5999);
		send_sample(SRC_A, 64'd6000);
		send_sample(SRC_EVAL, 64'd6050);
		send_sample(SRC_EVAL, 64'd6101);
		send_sample(SRC_A, 64'd6110);
		send_sample(SRC_B, 64'd6120);
		send_sample(SRC_B, 64'd6130);
		send_sample(SRC_UNUSED, 64'd6140);
		send_sample(SRC_A, 64'd6150);
		send_sample(SRC_EVAL, 64'd6250);
		send_sample(SRC_EVAL, 64'd6251);
		send_sample(SRC_A, 64'd6310);
		send_sample(SRC_B, 64'd6320);
		send_sample(SRC_A, 64'd5000);
		send_sample(SRC_EVAL, '1);
		drain();

		// widest timeout with strict policy and extreme times
		write_all(1'b0, '1, '1, '1);
		send_sample(SRC_A, 64'd0);
		send_sample(SRC_B, '1);
		send_sample(SRC_EVAL, '1);
		send_sample(SRC_B, '1);
		send_sample(SRC_A, '1);
		send_sample(SRC_A, 64'd0);
		drain();

		// zero timeout: fresh only at the exact arrival time
		write_all(1'b1, 64'd0, 64'd0, 64'd0);
		send_sample(SRC_A, 64'd5);
		send_sample(SRC_B, 64'd5);
		send_sample(SRC_EVAL, 64'd6);
		drain();

		cur = 64'd1000;
		drop = 0;
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p % 4)
				0: tmo = 64'($urandom_range(16, 2000));
				1: tmo = 64'd1;
				2: tmo = '1;
				default: tmo = 64'($urandom_range(0, 50));
			endcase
			case (p % 3)
				0: begin grace = '0; t_start = '1; end
				1: begin grace = '1; t_start = '0; end
				default: begin grace = {$urandom, $urandom}; t_start = {$urandom, $urandom}; end
			endcase
			write_all(p[0], tmo, grace, t_start);
			calm = (p == 5);
			span = (tmo > 64'd20000) ? 20000 : int'(tmo) + 1;
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(0, 29) == 0)
					drop = $urandom_range(0, 2);
				r = $urandom_range(0, 99);
				if (r < 3)
					cur = {$urandom, $urandom};
				else if (r < 6)
					cur = cur - $urandom_range(0, span);
				else if (r < 8)
					cur = '1 - $urandom_range(0, span);
				else if (r < 18)
					cur = cur + $urandom_range(0, 3 * span);
				else
					cur = cur + $urandom_range(0, span / 2 + 1);
				r = $urandom_range(0, 19);
				if (r == 0)
					src = SRC_EVAL;
				else if (r == 1)
					src = SRC_UNUSED;
				else
					src = $urandom_range(0, 1) ? SRC_A : SRC_B;
				// a dropped sensor goes quiet; the slot becomes an evaluation
				if ((drop == 1 && src == SRC_A) || (drop == 2 && src == SRC_B))
					src = SRC_EVAL;
				send_sample(src, cur);
				if (!calm && $urandom_range(0, 149) == 0)
					drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("%0d samples over %0d register settings, %0d verdicts checked",
			samples, settings, board.checked);
		$display("modes reached (bit per state) %b, %0d buffer flushes",
			board.visited, board.flushes);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d verdicts outstanding", board.errors, board.pending());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
